// ===== rtl/core/sfcp_pkg.sv =====
package sfcp_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int CHAR_W        = 8;
    localparam int FREQ_W        = 16;
    localparam int TICK_W        = 24;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = TICK_W;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 1'd1;

    localparam logic [FREQ_W-1:0] MAX_FREQ_RESET  = 16'd20000;
    localparam logic [TICK_W-1:0] TICK_RATE_RESET = 24'd1000000;
    localparam logic [FREQ_W-1:0] FREQ_RESET      = 16'd1000;

    typedef struct packed {
        logic              number_ok;
        logic              negative;
        logic [FREQ_W-1:0] value;
    } cmd_t;

    function automatic logic [CHAR_W-1:0] prefix_char(input logic [2:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h46;
            3'd1:    ch = 8'h52;
            3'd2:    ch = 8'h45;
            3'd3:    ch = 8'h51;
            3'd4:    ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/sfcp_front.sv =====
module sfcp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sfcp_pkg::CHAR_W-1:0] rx_byte,
    input  logic                        q_full,
    output logic                        push,
    output sfcp_pkg::cmd_t              push_cmd
);

    localparam logic [3:0] PH_AFTER_EQ   = 4'd5;
    localparam logic [3:0] PH_AFTER_SIGN = 4'd6;
    localparam logic [3:0] PH_DIGITS     = 4'd7;
    localparam logic [3:0] PH_DONE       = 4'd8;
    localparam logic [3:0] PH_FAIL       = 4'd9;

    localparam logic [sfcp_pkg::CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [sfcp_pkg::CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [sfcp_pkg::CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [sfcp_pkg::CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [sfcp_pkg::CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [sfcp_pkg::CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [sfcp_pkg::CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [sfcp_pkg::CHAR_W-1:0] CH_CR    = 8'h0D;

    logic [sfcp_pkg::LEN_W-1:0]  len_reg, len_next, len_inc;
    logic [3:0]                  phase_reg, phase_next, phase_adv;
    logic                        neg_reg, neg_next, neg_adv;
    logic [sfcp_pkg::FREQ_W-1:0] digit_reg, digit_next, digit_adv;
    logic                        accept, printable, is_digit, is_eol;
    logic [19:0]                 digit_sum;
    logic [sfcp_pkg::CHAR_W-1:0] digit_ofs;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign printable = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);
    assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_eol    = (rx_byte == CH_LF) || (rx_byte == CH_CR);
    assign len_inc   = len_reg + 1'b1;
    assign digit_ofs = rx_byte - CH_ZERO;
    assign digit_sum = {digit_reg, 3'b000} + {3'b000, digit_reg, 1'b0}
                     + {12'd0, digit_ofs};

    always_comb
    begin
        phase_adv = phase_reg;
        neg_adv   = neg_reg;
        digit_adv = digit_reg;
        if (phase_reg < PH_AFTER_EQ)
        begin
            phase_adv = (rx_byte == sfcp_pkg::prefix_char(phase_reg[2:0]))
                      ? phase_reg + 4'd1 : PH_FAIL;
        end
        else if (phase_reg == PH_AFTER_EQ)
        begin
            if (rx_byte == CH_SPACE)
            begin
                phase_adv = phase_reg;
            end
            else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))
            begin
                neg_adv   = (rx_byte == CH_MINUS);
                phase_adv = PH_AFTER_SIGN;
            end
            else if (!is_digit)
            begin
                phase_adv = PH_FAIL;
            end
        end
        else if (phase_reg == PH_AFTER_SIGN)
        begin
            if (!is_digit)
            begin
                phase_adv = PH_FAIL;
            end
        end
        else if (phase_reg == PH_DIGITS)
        begin
            if (!is_digit)
            begin
                phase_adv = PH_DONE;
            end
        end
        // accumulate a digit while the number field is open
        if (is_digit && ((phase_reg == PH_AFTER_EQ) || (phase_reg == PH_AFTER_SIGN)
                         || (phase_reg == PH_DIGITS)))
        begin
            digit_adv = (digit_sum[19:16] != 4'd0) ? 16'hFFFF : digit_sum[15:0];
            phase_adv = PH_DIGITS;
        end
    end

    always_comb
    begin
        len_next   = len_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        digit_next = digit_reg;
        push       = 1'b0;
        if (accept)
        begin
            if (printable)
            begin
                len_next   = len_inc;
                phase_next = phase_adv;
                neg_next   = neg_adv;
                digit_next = digit_adv;
                if (len_inc >= sfcp_pkg::LEN_W'(sfcp_pkg::LINE_CAPACITY - 1))
                begin
                    len_next   = '0;
                    phase_next = 4'd0;
                    neg_next   = 1'b0;
                    digit_next = '0;
                end
            end
            else if (is_eol)
            begin
                push       = (len_reg != '0);
                len_next   = '0;
                phase_next = 4'd0;
                neg_next   = 1'b0;
                digit_next = '0;
            end
        end
    end

    assign push_cmd.number_ok = (phase_reg == PH_DIGITS) || (phase_reg == PH_DONE);
    assign push_cmd.negative  = neg_reg;
    assign push_cmd.value     = digit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            phase_reg <= 4'd0;
            neg_reg   <= 1'b0;
            digit_reg <= '0;
        end
        else
        begin
            len_reg   <= len_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== rtl/core/sfcp_queue.sv =====
module sfcp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfcp_pkg::cmd_t push_cmd,
    input  logic           pop,
    output sfcp_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = $clog2(sfcp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sfcp_pkg::QUEUE_DEPTH + 1);

    sfcp_pkg::cmd_t     entry_reg [sfcp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(sfcp_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/sfcp_back.sv =====
module sfcp_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sfcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfcp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            q_empty,
    input  sfcp_pkg::cmd_t                  head,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sfcp_pkg::STATUS_W-1:0]   status,
    output logic [sfcp_pkg::FREQ_W-1:0]     frequency,
    output logic [sfcp_pkg::TICK_W-1:0]     reload
);

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_DIV  = 2'd1;
    localparam logic [1:0] BK_HOLD = 2'd2;

    localparam int FW    = sfcp_pkg::FREQ_W;
    localparam int TW    = sfcp_pkg::TICK_W;
    localparam int CNT_W = $clog2(TW);

    logic [1:0]                    state_reg, state_next;
    logic [FW-1:0]                 max_reg, max_next;
    logic [TW-1:0]                 tick_reg, tick_next;
    logic [FW-1:0]                 freq_reg, freq_next;
    logic [FW-1:0]                 rem_reg, rem_next;
    logic [TW-1:0]                 quo_reg, quo_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [sfcp_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [TW-1:0]                 res_reload_reg, res_reload_next;
    logic                          out_valid_reg, out_valid_next;
    logic [sfcp_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [FW-1:0]                 out_freq_reg, out_freq_next;
    logic [TW-1:0]                 out_reload_reg, out_reload_next;
    logic                          out_free, div_ge;
    logic [FW:0]                   div_shift, div_diff;
    logic [TW-1:0]                 div_quo;

    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == BK_IDLE) && !q_empty;
    assign div_shift = {rem_reg, quo_reg[TW-1]};
    assign div_diff  = div_shift - {1'b0, freq_reg};
    assign div_ge    = !div_diff[FW];
    assign div_quo   = {quo_reg[TW-2:0], div_ge};

    always_comb
    begin
        max_next  = max_reg;
        tick_next = tick_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                sfcp_pkg::CFG_MAX_FREQ:  max_next  = cfg_data[FW-1:0];
                sfcp_pkg::CFG_TICK_RATE: tick_next = cfg_data[TW-1:0];
                default:                 max_next  = max_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        freq_next       = freq_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_reload_next = res_reload_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_freq_next   = out_freq_reg;
        out_reload_next = out_reload_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    res_reload_next = '0;
                    if (!head.number_ok)
                    begin
                        res_status_next = sfcp_pkg::STATUS_UNKNOWN;
                        state_next      = BK_HOLD;
                    end
                    else if (head.negative || (head.value == '0) || (head.value > max_reg))
                    begin
                        res_status_next = sfcp_pkg::STATUS_RANGE;
                        state_next      = BK_HOLD;
                    end
                    else
                    begin
                        res_status_next = sfcp_pkg::STATUS_OK;
                        freq_next       = head.value;
                        rem_next        = '0;
                        quo_next        = tick_reg;
                        cnt_next        = CNT_W'(TW - 1);
                        state_next      = BK_DIV;
                    end
                end
            end
            BK_DIV:
            begin
                rem_next = div_ge ? div_diff[FW-1:0] : div_shift[FW-1:0];
                quo_next = div_quo;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    res_reload_next = (div_quo == '0) ? '0 : div_quo - 1'b1;
                    state_next      = BK_HOLD;
                end
            end
            BK_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_freq_next   = freq_reg;
                    out_reload_next = res_reload_reg;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            max_reg       <= sfcp_pkg::MAX_FREQ_RESET;
            tick_reg      <= sfcp_pkg::TICK_RATE_RESET;
            freq_reg      <= sfcp_pkg::FREQ_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_reg       <= max_next;
            tick_reg      <= tick_next;
            freq_reg      <= freq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_reload_reg <= res_reload_next;
        out_status_reg <= out_status_next;
        out_freq_reg   <= out_freq_next;
        out_reload_reg <= out_reload_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign frequency = out_freq_reg;
    assign reload    = out_reload_reg;

endmodule

// ===== rtl/core/serial_frequency_command_parser_top.sv =====
// Serial frequency command parser. Takes one received byte per cycle while the
// two-entry command queue has room; bytes are classified and parsed in the
// front end as they arrive, so only line ends cost extra time. A line that
// ends in an accepted value passes the back end's divide state, where the
// restoring divider yields one reload quotient bit per cycle, then its hold
// state; a rejected or unknown line goes straight to hold. An output register
// holds results, so the back end starts the next command while the last
// transaction waits on out_stall. Configuration writes are taken every cycle.
module serial_frequency_command_parser_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sfcp_pkg::CHAR_W-1:0]     rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sfcp_pkg::STATUS_W-1:0]   status,
    output logic [sfcp_pkg::FREQ_W-1:0]     frequency,
    output logic [sfcp_pkg::TICK_W-1:0]     reload,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfcp_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic           q_full, q_empty, push, pop;
    sfcp_pkg::cmd_t push_cmd, head;

    assign cfg_ready = 1'b1;

    sfcp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    sfcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    sfcp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .frequency (frequency),
        .reload    (reload)
    );

endmodule

// ===== rtl/core/sfcp_checker.sv =====
module sfcp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [sfcp_pkg::STATUS_W-1:0] status,
    input logic [sfcp_pkg::FREQ_W-1:0]   frequency,
    input logic [sfcp_pkg::TICK_W-1:0]   reload
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(frequency) && $stable(reload))
        else $error("stalled result transaction changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == sfcp_pkg::STATUS_OK) || (status == sfcp_pkg::STATUS_RANGE)
            || (status == sfcp_pkg::STATUS_UNKNOWN))
        else $error("undefined status code");

    a_reload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != sfcp_pkg::STATUS_OK) |-> reload == '0)
        else $error("reload nonzero on rejected line");

    a_freq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frequency != '0)
        else $error("zero frequency reported");

endmodule

bind serial_frequency_command_parser_top sfcp_checker u_sfcp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .frequency (frequency),
    .reload    (reload)
);

// ===== tb/serial_frequency_command_parser_top_test.sv =====
module serial_frequency_command_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam int unsigned SATURATED  = 65535;
    localparam int SETTLE_CYCLES       = 40;
    localparam int WATCHDOG_LIMIT      = 4000;
    localparam int PHASE_ITEMS         = 50;

    typedef struct {
        logic [sfcp_pkg::STATUS_W-1:0] status;
        logic [sfcp_pkg::FREQ_W-1:0]   frequency;
        logic [sfcp_pkg::TICK_W-1:0]   reload;
    } freq_reply_t;

    class freq_command_scoreboard;
        typedef enum int {MATCH_PREFIX, AFTER_EQUALS, AFTER_SIGN, IN_DIGITS, DIGITS_DONE,
                          MISMATCH} parse_state_t;

        string        cmd_prefix = "FREQ=";
        int unsigned  max_freq   = sfcp_pkg::MAX_FREQ_RESET;
        int unsigned  tick_rate  = sfcp_pkg::TICK_RATE_RESET;
        int unsigned  cur_freq   = sfcp_pkg::FREQ_RESET;
        int unsigned  line_len;
        int unsigned  prefix_pos;
        parse_state_t state;
        bit           negative;
        int unsigned  value;
        int unsigned  errors;
        freq_reply_t  expected_replies[$];

        function new();
            restart_line();
        endfunction

        function void restart_line();
            line_len   = 0;
            prefix_pos = 0;
            state      = MATCH_PREFIX;
            negative   = 1'b0;
            value      = 0;
        endfunction

        function void add_digit(logic [7:0] c);
            int unsigned v;
            v = value * 10 + (c - CHAR_ZERO);
            value = (v > SATURATED) ? SATURATED : v;
            state = IN_DIGITS;
        endfunction

        function void set_register(logic [sfcp_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
            if (idx == sfcp_pkg::CFG_MAX_FREQ)
                max_freq = data & 32'hFFFF;
            else if (idx == sfcp_pkg::CFG_TICK_RATE)
                tick_rate = data & 32'hFF_FFFF;
        endfunction

        function int unsigned pending();
            return expected_replies.size();
        endfunction

        function void note_byte(logic [7:0] c);
            freq_reply_t r;
            int unsigned q;
            bit          is_digit;
            is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
            if (c >= CHAR_SPACE && c <= CHAR_TILDE)
            begin
                line_len++;
                case (state)
                    MATCH_PREFIX:
                    begin
                        if (c == cmd_prefix[prefix_pos])
                        begin
                            prefix_pos++;
                            if (prefix_pos == cmd_prefix.len())
                                state = AFTER_EQUALS;
                        end
                        else
                            state = MISMATCH;
                    end
                    AFTER_EQUALS:
                    begin
                        if (c == CHAR_SPACE)
                            state = AFTER_EQUALS;
                        else if (c == CHAR_PLUS || c == CHAR_MINUS)
                        begin
                            negative = (c == CHAR_MINUS);
                            state = AFTER_SIGN;
                        end
                        else if (is_digit)
                            add_digit(c);
                        else
                            state = MISMATCH;
                    end
                    AFTER_SIGN:
                    begin
                        if (is_digit)
                            add_digit(c);
                        else
                            state = MISMATCH;
                    end
                    IN_DIGITS:
                    begin
                        if (is_digit)
                            add_digit(c);
                        else
                            state = DIGITS_DONE;
                    end
                    default:
                        state = state;
                endcase
                if (line_len >= sfcp_pkg::LINE_CAPACITY - 1)
                    restart_line();
                return;
            end
            if (c != CHAR_LF && c != CHAR_CR)
                return;
            if (line_len == 0)
                return;
            r.reload = '0;
            if (state != IN_DIGITS && state != DIGITS_DONE)
                r.status = sfcp_pkg::STATUS_UNKNOWN;
            else if (negative || value == 0 || value > max_freq)
                r.status = sfcp_pkg::STATUS_RANGE;
            else
            begin
                r.status = sfcp_pkg::STATUS_OK;
                cur_freq = value;
                q = tick_rate / cur_freq;
                r.reload = (q == 0) ? '0 : sfcp_pkg::TICK_W'(q - 1);
            end
            r.frequency = sfcp_pkg::FREQ_W'(cur_freq);
            restart_line();
            expected_replies.push_back(r);
        endfunction

        function void check_result(logic [sfcp_pkg::STATUS_W-1:0] st,
                                   logic [sfcp_pkg::FREQ_W-1:0] fr,
                                   logic [sfcp_pkg::TICK_W-1:0] rl);
            freq_reply_t e;
            if (expected_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status %0d frequency %0d reload %0d",
                         $time, st, fr, rl);
                return;
            end
            e = expected_replies.pop_front();
            if (st !== e.status)
            begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            end
            if (fr !== e.frequency)
            begin
                errors++;
                $display("%0t: frequency expected %0d actual %0d", $time, e.frequency, fr);
            end
            if (rl !== e.reload)
            begin
                errors++;
                $display("%0t: reload expected %0d actual %0d", $time, e.reload, rl);
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [sfcp_pkg::CHAR_W-1:0]     rx_byte = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [sfcp_pkg::STATUS_W-1:0]   status;
    logic [sfcp_pkg::FREQ_W-1:0]     frequency;
    logic [sfcp_pkg::TICK_W-1:0]     reload;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [sfcp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sfcp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    freq_command_scoreboard sb = new();
    bit          no_idling;
    int unsigned stall_left;
    int unsigned stalled_cycles;
    int unsigned items_sent;
    int unsigned max_freq_setting = sfcp_pkg::MAX_FREQ_RESET;

    serial_frequency_command_parser_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .frequency (frequency),
        .reload    (reload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall = 1'b1;
        end
        else if (!no_idling && rst_n && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            out_stall = 1'b1;
        end
        else
            out_stall = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stalled_cycles = 0;
        else
        begin
            if (out_valid && !out_stall)
                sb.check_result(status, frequency, reload);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
    end

    initial
    begin
        while (stalled_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        @(negedge clk);
        if (!no_idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte = b;
        do @(posedge clk); while (in_stall);
        sb.note_byte(b);
        if ((b >= CHAR_SPACE && b <= CHAR_TILDE) || b == CHAR_CR || b == CHAR_LF)
            items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_repeat(logic [7:0] b, int count);
        repeat (count) send_byte(b);
    endtask

    task automatic end_line();
        send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    endtask

    // hold the sender until every pending result has drained
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [sfcp_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data[sfcp_pkg::CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(idx, data);
        if (idx == sfcp_pkg::CFG_MAX_FREQ)
            max_freq_setting = data & 32'hFFFF;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic reconfigure(int unsigned max_freq, int unsigned tick);
        drain_results();
        write_register(sfcp_pkg::CFG_MAX_FREQ, max_freq);
        write_register(sfcp_pkg::CFG_TICK_RATE, tick);
    endtask

    function automatic logic [7:0] odd_byte();
        logic [7:0] b;
        b = $urandom_range(0, 1) ? 8'($urandom_range(127, 255)) : 8'($urandom_range(0, 31));
        if (b == CHAR_CR || b == CHAR_LF)
            b = 8'h00;
        return b;
    endfunction

    task automatic send_random_line();
        int unsigned kind;
        int unsigned v;
        int unsigned n;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            send_text("FREQ=");
            send_repeat(CHAR_SPACE, $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
            case ($urandom_range(0, 5))
                0: send_byte(CHAR_PLUS);
                1: send_byte(CHAR_MINUS);
                default: ;
            endcase
            if ($urandom_range(0, 7) == 0)
                send_byte(odd_byte());
            case ($urandom_range(0, 6))
                0: v = 0;
                1: v = $urandom_range(1, 9);
                2: v = max_freq_setting + $urandom_range(0, 1);
                3: v = $urandom_range(65530, 99999999);
                default: v = $urandom_range(1, max_freq_setting);
            endcase
            if ($urandom_range(0, 7) == 0)
                send_byte(CHAR_ZERO);
            send_text($sformatf("%0d", v));
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(32, 126)));
        end
        else if (kind == 6)
        begin
            n = $urandom_range(1, 10);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind == 7)
        begin
            send_text(sb.cmd_prefix.substr(0, $urandom_range(0, 4)));
            send_byte(8'($urandom_range(32, 126)));
            if ($urandom_range(0, 1))
                send_text($sformatf("%0d", $urandom_range(0, 30000)));
        end
        else if (kind == 8)
        begin
            n = $urandom_range(20, 40);
            repeat (n) send_byte(8'($urandom_range(32, 126)));
            if ($urandom_range(0, 1))
                send_text($sformatf("FREQ=%0d", $urandom_range(1, max_freq_setting)));
        end
        end_line();
    endtask

    task automatic random_phase();
        int unsigned start;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
            send_random_line();
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        send_byte(CHAR_CR);
        send_text("FREQ=500");
        send_byte(CHAR_CR);
        send_text("FREQ=  -5");
        send_byte(CHAR_LF);
        send_text("FREQ=0");
        send_byte(CHAR_CR);
        send_text("FREQ=+20001x");
        send_byte(CHAR_LF);
        send_text("FREQ=99999999");
        send_byte(CHAR_CR);
        send_text("FREQ=");
        send_byte(CHAR_CR);
        send_text("freq=5");
        send_byte(CHAR_LF);
        send_text("FREQ= +");
        send_byte(CHAR_CR);
        send_text("FREQ =7");
        send_byte(CHAR_CR);
        send_text("FR");
        send_byte(8'h00);
        send_text("EQ=7");
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(CHAR_CR);
        send_text("FREQ=12 34");
        send_byte(CHAR_LF);
        send_text("FREQ=123");
        send_repeat("a", sfcp_pkg::LINE_CAPACITY - 1 - 8);
        send_text("FREQ=9");
        send_byte(CHAR_CR);
        send_text("FREQ=12");
        send_repeat("b", sfcp_pkg::LINE_CAPACITY - 2 - 7);
        send_byte(CHAR_CR);

        reconfigure(1, 1);
        send_text("FREQ=1");
        send_byte(CHAR_CR);
        send_text("FREQ=2");
        send_byte(CHAR_LF);

        reconfigure(65534, 16777215);
        send_text("FREQ=65534");
        send_byte(CHAR_CR);
        send_text("FREQ=65535");
        send_byte(CHAR_CR);
        send_text("FREQ=1");
        send_byte(CHAR_LF);

        reconfigure(65534, 1);
        send_text("FREQ=3");
        send_byte(CHAR_CR);

        reconfigure($urandom_range(1, 65534), $urandom_range(1, 16777215));
        random_phase();

        reconfigure(65534, 16777215);
        random_phase();
        drain_results();
        random_phase();

        reconfigure($urandom_range(1, 50), $urandom_range(1, 100));
        random_phase();

        no_idling = 1'b1;
        reconfigure($urandom_range(1000, 65534), $urandom_range(1, 16777215));
        random_phase();

        drain_results();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
